/* hdl/tfsp_pkg.sv */
// shared types, constants and register map for the fingertip surface point block
// no dependencies
package tfsp_pkg;

  localparam int NumW  = 61;
  localparam int DenW  = 46;
  localparam int QuotW = 32;
  localparam int CmpW  = DenW + QuotW + 1;

  localparam logic [3:0] AddrMinRange = 4'h0;
  localparam logic [3:0] AddrMaxRange = 4'h4;
  localparam logic [3:0] AddrOffset   = 4'h8;
  localparam logic [3:0] AddrSep      = 4'hC;

  localparam logic [21:0] MinRangeRst = 22'd20000;
  localparam logic [21:0] MaxRangeRst = 22'd2000000;
  localparam logic [15:0] OffsetRst   = 16'd2000;
  localparam logic [16:0] SepRst      = 17'd4000;

  localparam logic [31:0] CurvMax = 32'h7FFF_FFFF;
  localparam logic [31:0] CurvMin = 32'h8000_0000;

  typedef logic signed [24:0] v25_t;

  typedef enum logic [1:0] {
    KindA   = 2'd0,
    KindB   = 2'd1,
    KindSum = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PhA   = 3'b001,
    PhB   = 3'b010,
    PhSum = 3'b100
  } phase_e;

  typedef struct packed {
    logic [21:0] min_range;
    logic [21:0] max_range;
    logic [15:0] sensor_offset;
    logic [16:0] sensor_separation;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [23:0] tip_x;
    logic signed [23:0] tip_y;
    logic signed [23:0] tip_z;
    logic [21:0]        dist_a;
    logic [21:0]        dist_b;
    logic               flag_a;
    logic               flag_b;
  } in_t;

  typedef struct {
    v25_t vec_a [3];
    v25_t vec_b [3];
    v25_t surf_a [3];
    v25_t surf_b [3];
    v25_t beam [3];
    logic ok_a;
    logic ok_b;
    logic cok;
    logic neg;
    logic dz;
  } geo_t;

endpackage

/* hdl/tfsp_if.sv */
// word channels of the fingertip surface point block, input and result side
// no dependencies
interface tfsp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [23:0] tip_x;
  logic signed [23:0] tip_y;
  logic signed [23:0] tip_z;
  logic [21:0]        dist_a;
  logic [21:0]        dist_b;
  logic               flag_a;
  logic               flag_b;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, tip_x, tip_y, tip_z,
                  dist_a, dist_b, flag_a, flag_b, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, tip_x, tip_y, tip_z,
                dist_a, dist_b, flag_a, flag_b, output ready);
endinterface

interface tfsp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [24:0] vec_x;
  logic signed [24:0] vec_y;
  logic signed [24:0] vec_z;
  logic signed [24:0] surf_x;
  logic signed [24:0] surf_y;
  logic signed [24:0] surf_z;
  logic               reading_ok;
  logic signed [31:0] curvature;
  logic               curvature_ok;
  logic               last;

  modport source (output valid, kind, vec_x, vec_y, vec_z, surf_x, surf_y, surf_z,
                  reading_ok, curvature, curvature_ok, last, input ready);
  modport sink (input valid, kind, vec_x, vec_y, vec_z, surf_x, surf_y, surf_z,
                reading_ok, curvature, curvature_ok, last, output ready);
endinterface

/* hdl/tfsp_geom.sv */
// four-stage geometry pipeline: rotation columns, sensor positions, surface points
// and the dividend and divisor of the curvature; uses tfsp_pkg
module tfsp_geom (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  tfsp_pkg::in_t    in_i,
  input  tfsp_pkg::cfg_t   cfg_i,
  output logic             valid_o,
  output tfsp_pkg::geo_t   geo_o,
  output logic [tfsp_pkg::NumW-1:0] num_o,
  output logic [tfsp_pkg::DenW-1:0] den_o
);
  import tfsp_pkg::*;

  localparam logic signed [19:0] OneQ14 = 20'sd16384;
  localparam logic [20:0] CurvScale = 21'd2000000;

  function automatic logic signed [19:0] rnd13(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic sub);
    logic signed [33:0] t;
    t = sub ? (34'(a) - 34'(b) + 34'sd4096) : (34'(a) + 34'(b) + 34'sd4096);
    return 20'(t >>> 13);
  endfunction

  function automatic logic signed [27:0] rnd14(input logic signed [42:0] v);
    logic signed [43:0] t;
    t = 44'(v) + 44'sd8192;
    return 28'(t >>> 14);
  endfunction

  function automatic v25_t sat25(input logic signed [29:0] v);
    v25_t r;
    if (v > 30'sd16777215) begin
      r = 25'sh0FF_FFFF;
    end else if (v < -30'sd16777216) begin
      r = 25'sh100_0000;
    end else begin
      r = 25'(v);
    end
    return r;
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  logic signed [31:0] pxz_q, pyw_q, pyz_q, pxw_q, pxx_q, pyy_q, pzz_q, pxy_q, pzw_q;
  logic signed [23:0] tip1_q [3];
  logic [21:0]        da1_q, db1_q, mag1_q;
  logic               oka1_q, okb1_q, neg1_q;
  logic signed [22:0] dd;

  // stage 2
  logic signed [19:0] beam2_q [3];
  logic signed [19:0] xcol2_q [3];
  logic [43:0]        magsq2_q;
  logic [33:0]        sepsq2_q;
  logic signed [23:0] tip2_q [3];
  logic [21:0]        da2_q, db2_q, mag2_q;
  logic               oka2_q, okb2_q, neg2_q;

  // stage 3
  logic signed [36:0] off3_q [3];
  logic signed [42:0] dba3_q [3];
  logic signed [42:0] dbb3_q [3];
  logic [42:0]        num3_q;
  logic [44:0]        den3_q;
  logic signed [19:0] beam3_q [3];
  logic signed [23:0] tip3_q [3];
  logic               oka3_q, okb3_q, neg3_q;

  // stage 4
  geo_t               geo_d, geo_q;
  logic [NumW-1:0]    num_q;
  logic [DenW-1:0]    den_q;

  assign dd = $signed({1'b0, in_i.dist_a}) - $signed({1'b0, in_i.dist_b});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxz_q     <= in_i.quat_x * in_i.quat_z;
      pyw_q     <= in_i.quat_y * in_i.quat_w;
      pyz_q     <= in_i.quat_y * in_i.quat_z;
      pxw_q     <= in_i.quat_x * in_i.quat_w;
      pxx_q     <= in_i.quat_x * in_i.quat_x;
      pyy_q     <= in_i.quat_y * in_i.quat_y;
      pzz_q     <= in_i.quat_z * in_i.quat_z;
      pxy_q     <= in_i.quat_x * in_i.quat_y;
      pzw_q     <= in_i.quat_z * in_i.quat_w;
      tip1_q[0] <= in_i.tip_x;
      tip1_q[1] <= in_i.tip_y;
      tip1_q[2] <= in_i.tip_z;
      da1_q     <= in_i.dist_a;
      db1_q     <= in_i.dist_b;
      oka1_q    <= in_i.flag_a && (in_i.dist_a >= cfg_i.min_range)
                   && (in_i.dist_a <= cfg_i.max_range);
      okb1_q    <= in_i.flag_b && (in_i.dist_b >= cfg_i.min_range)
                   && (in_i.dist_b <= cfg_i.max_range);
      neg1_q    <= dd[22];
      mag1_q    <= dd[22] ? 22'(-dd) : 22'(dd);

      beam2_q[0] <= rnd13(pxz_q, pyw_q, 1'b0);
      beam2_q[1] <= rnd13(pyz_q, pxw_q, 1'b1);
      beam2_q[2] <= OneQ14 - rnd13(pxx_q, pyy_q, 1'b0);
      xcol2_q[0] <= OneQ14 - rnd13(pyy_q, pzz_q, 1'b0);
      xcol2_q[1] <= rnd13(pxy_q, pzw_q, 1'b0);
      xcol2_q[2] <= rnd13(pxz_q, pyw_q, 1'b1);
      magsq2_q   <= 44'(mag1_q) * 44'(mag1_q);
      sepsq2_q   <= 34'(cfg_i.sensor_separation) * 34'(cfg_i.sensor_separation);
      tip2_q     <= tip1_q;
      da2_q      <= da1_q;
      db2_q      <= db1_q;
      mag2_q     <= mag1_q;
      oka2_q     <= oka1_q;
      okb2_q     <= okb1_q;
      neg2_q     <= neg1_q;

      for (int i = 0; i < 3; i++) begin
        off3_q[i] <= $signed({1'b0, cfg_i.sensor_offset}) * xcol2_q[i];
        dba3_q[i] <= $signed({1'b0, da2_q}) * beam2_q[i];
        dbb3_q[i] <= $signed({1'b0, db2_q}) * beam2_q[i];
      end
      num3_q  <= 43'(mag2_q) * 43'(CurvScale);
      den3_q  <= 45'(magsq2_q) + 45'(sepsq2_q);
      beam3_q <= beam2_q;
      tip3_q  <= tip2_q;
      oka3_q  <= oka2_q;
      okb3_q  <= okb2_q;
      neg3_q  <= neg2_q;

      geo_q <= geo_d;
      num_q <= NumW'({num3_q, 17'b0}) + NumW'(den3_q);
      den_q <= {den3_q, 1'b0};
    end
  end

  always_comb begin
    logic signed [27:0] oo;
    logic signed [29:0] pa, pb;
    for (int i = 0; i < 3; i++) begin
      oo = rnd14(43'(off3_q[i]));
      pa = 30'(tip3_q[i]) + 30'(oo);
      pb = 30'(tip3_q[i]) - 30'(oo);
      geo_d.vec_a[i]  = sat25(pa);
      geo_d.vec_b[i]  = sat25(pb);
      geo_d.surf_a[i] = oka3_q ? sat25(pa + 30'(rnd14(dba3_q[i]))) : '0;
      geo_d.surf_b[i] = okb3_q ? sat25(pb + 30'(rnd14(dbb3_q[i]))) : '0;
      geo_d.beam[i]   = 25'(beam3_q[i]);
    end
    geo_d.ok_a = oka3_q;
    geo_d.ok_b = okb3_q;
    geo_d.cok  = oka3_q && okb3_q;
    geo_d.neg  = neg3_q;
    geo_d.dz   = (den3_q == '0);
  end

  assign valid_o = v4_q;
  assign geo_o   = geo_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

/* hdl/tfsp_div.sv */
// pipelined restoring divider, an overflow check and then one quotient bit per stage,
// carrying the geometry alongside and forming the saturated curvature at its end; uses tfsp_pkg
module tfsp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  tfsp_pkg::geo_t            geo_i,
  input  logic [tfsp_pkg::NumW-1:0] num_i,
  input  logic [tfsp_pkg::DenW-1:0] den_i,
  output logic                      valid_o,
  output tfsp_pkg::geo_t            geo_o,
  output logic [31:0]               curv_o
);
  import tfsp_pkg::*;

  typedef struct {
    logic [NumW-1:0]  rem;
    logic [DenW-1:0]  dv;
    logic [QuotW-1:0] q;
    logic             ovf;
    geo_t             geo;
  } dstage_t;

  logic [QuotW:0]  v_q;
  dstage_t         s_q [QuotW+1];
  dstage_t         s_d [QuotW+1];
  logic [CmpW-1:0] sh [QuotW+1];
  logic [QuotW:0]  ge;

  always_comb begin
    sh[0] = '0;
    ge[0] = 1'b0;
    for (int j = 1; j <= QuotW; j++) begin
      sh[j] = CmpW'(s_q[j-1].dv) << (QuotW - j);
      ge[j] = CmpW'(s_q[j-1].rem) >= sh[j];
    end
  end

  always_comb begin
    s_d[0].rem = num_i;
    s_d[0].dv  = den_i;
    s_d[0].q   = '0;
    s_d[0].ovf = CmpW'(num_i) >= (CmpW'(den_i) << QuotW);
    s_d[0].geo = geo_i;
    for (int j = 1; j <= QuotW; j++) begin
      s_d[j] = s_q[j-1];
      if (ge[j]) begin
        s_d[j].rem          = s_q[j-1].rem - NumW'(sh[j]);
        s_d[j].q[QuotW - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QuotW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  always_comb begin
    logic [QuotW-1:0] q;
    q = s_q[QuotW].q;
    if (!s_q[QuotW].geo.cok || s_q[QuotW].geo.dz) begin
      curv_o = '0;
    end else if (!s_q[QuotW].geo.neg) begin
      curv_o = (s_q[QuotW].ovf || q[QuotW-1]) ? CurvMax : q;
    end else begin
      curv_o = (s_q[QuotW].ovf || (q > CurvMin)) ? CurvMin : (~q + 32'd1);
    end
  end

  assign valid_o = v_q[QuotW];
  assign geo_o   = s_q[QuotW].geo;

endmodule

/* hdl/tfsp_ser.sv */
// output stage: holds one finished fingertip and sends its three result words
// uses tfsp_pkg and tfsp_out_if
module tfsp_ser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  tfsp_pkg::geo_t geo_i,
  input  logic [31:0]    curv_i,
  output logic           free_o,
  tfsp_out_if.source     out_o
);
  import tfsp_pkg::*;

  logic        busy_q;
  phase_e      ph_q;
  geo_t        geo_q;
  logic [31:0] curv_q;
  logic        fire, load;

  assign fire   = busy_q && out_o.ready;
  assign free_o = !busy_q || (ph_q == PhSum && out_o.ready);
  assign load   = valid_i && free_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= PhA;
    end else if (load) begin
      busy_q <= 1'b1;
      ph_q   <= PhA;
    end else if (fire) begin
      case (ph_q)
        PhA:     ph_q <= PhB;
        PhB:     ph_q <= PhSum;
        PhSum:   busy_q <= 1'b0;
        default: ph_q <= PhA;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      geo_q  <= geo_i;
      curv_q <= curv_i;
    end
  end

  assign out_o.valid = busy_q;

  always_comb begin
    out_o.kind         = KindSum;
    out_o.vec_x        = geo_q.beam[0];
    out_o.vec_y        = geo_q.beam[1];
    out_o.vec_z        = geo_q.beam[2];
    out_o.surf_x       = '0;
    out_o.surf_y       = '0;
    out_o.surf_z       = '0;
    out_o.reading_ok   = 1'b0;
    out_o.curvature    = curv_q;
    out_o.curvature_ok = geo_q.cok;
    out_o.last         = 1'b1;
    case (ph_q)
      PhA: begin
        out_o.kind         = KindA;
        out_o.vec_x        = geo_q.vec_a[0];
        out_o.vec_y        = geo_q.vec_a[1];
        out_o.vec_z        = geo_q.vec_a[2];
        out_o.surf_x       = geo_q.surf_a[0];
        out_o.surf_y       = geo_q.surf_a[1];
        out_o.surf_z       = geo_q.surf_a[2];
        out_o.reading_ok   = geo_q.ok_a;
        out_o.curvature    = '0;
        out_o.curvature_ok = 1'b0;
        out_o.last         = 1'b0;
      end
      PhB: begin
        out_o.kind         = KindB;
        out_o.vec_x        = geo_q.vec_b[0];
        out_o.vec_y        = geo_q.vec_b[1];
        out_o.vec_z        = geo_q.vec_b[2];
        out_o.surf_x       = geo_q.surf_b[0];
        out_o.surf_y       = geo_q.surf_b[1];
        out_o.surf_z       = geo_q.surf_b[2];
        out_o.reading_ok   = geo_q.ok_b;
        out_o.curvature    = '0;
        out_o.curvature_ok = 1'b0;
        out_o.last         = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/tof_finger_surface_points.sv */
// fingertip time-of-flight surface points, top level with register port
// uses tfsp_pkg, tfsp_if, tfsp_geom, tfsp_div and tfsp_ser
// Each accepted fingertip gives three result words: sensor A, sensor B, then the
// summary with last set. One fingertip can enter every cycle unless the pipeline
// stalls, but the result channel sends one word a cycle while ready is high, so the
// sustained rate is one fingertip per three words, set by the output stage. A fingertip
// passes four geometry stages, 33 divider stages (an overflow check, then one
// quotient bit each) and the output register. The pipeline stalls as a whole only
// while a finished fingertip waits at its end. Registers: 0x0 min_range, 0x4 max_range,
// 0x8 sensor_offset, 0xC sensor_separation; write them only while idle.
module tof_finger_surface_points (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfsp_in_if.sink     in_i,
  tfsp_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tfsp_pkg::*;

  cfg_t            cfg_q;
  in_t             in_s;
  logic            en, wr;
  logic            geo_v, div_v, free;
  geo_t            geo, div_geo;
  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  logic [31:0]     curv;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_range         <= MinRangeRst;
      cfg_q.max_range         <= MaxRangeRst;
      cfg_q.sensor_offset     <= OffsetRst;
      cfg_q.sensor_separation <= SepRst;
    end else if (wr) begin
      case (paddr)
        AddrMinRange: cfg_q.min_range         <= pwdata[21:0];
        AddrMaxRange: cfg_q.max_range         <= pwdata[21:0];
        AddrOffset:   cfg_q.sensor_offset     <= pwdata[15:0];
        AddrSep:      cfg_q.sensor_separation <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrMinRange: prdata = 32'(cfg_q.min_range);
      AddrMaxRange: prdata = 32'(cfg_q.max_range);
      AddrOffset:   prdata = 32'(cfg_q.sensor_offset);
      AddrSep:      prdata = 32'(cfg_q.sensor_separation);
      default:      prdata = '0;
    endcase
  end

  assign in_s.quat_w = in_i.quat_w;
  assign in_s.quat_x = in_i.quat_x;
  assign in_s.quat_y = in_i.quat_y;
  assign in_s.quat_z = in_i.quat_z;
  assign in_s.tip_x  = in_i.tip_x;
  assign in_s.tip_y  = in_i.tip_y;
  assign in_s.tip_z  = in_i.tip_z;
  assign in_s.dist_a = in_i.dist_a;
  assign in_s.dist_b = in_i.dist_b;
  assign in_s.flag_a = in_i.flag_a;
  assign in_s.flag_b = in_i.flag_b;

  // the whole pipeline moves unless a finished fingertip cannot be handed over
  assign en         = free || !div_v;
  assign in_i.ready = en;

  tfsp_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .in_i    (in_s),
    .cfg_i   (cfg_q),
    .valid_o (geo_v),
    .geo_o   (geo),
    .num_o   (num),
    .den_o   (den)
  );

  tfsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geo_v),
    .geo_i   (geo),
    .num_i   (num),
    .den_i   (den),
    .valid_o (div_v),
    .geo_o   (div_geo),
    .curv_o  (curv)
  );

  tfsp_ser u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_v),
    .geo_i   (div_geo),
    .curv_i  (curv),
    .free_o  (free),
    .out_o   (out_o)
  );

`ifndef ASSERT_OFF
  a_sum_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && (out_o.kind == KindA) |=> out_o.valid)
    else $error("sensor B word missing after sensor A word");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> div_v)
    else $error("pipeline stalled with an empty last stage");

  a_curv_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last |-> (out_o.curvature == '0) && !out_o.curvature_ok)
    else $error("curvature on a sensor word");
`endif

endmodule

/* tb/sv/tb_top.sv */
// testbench for tof_finger_surface_points: fingertip words in, surface point words out
// uses tfsp_pkg and the channel interfaces of tfsp_if; expected words come from a
// scoreboard that models the rotation, range check, surface points and curvature
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tfsp_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic signed [24:0] vx, vy, vz;
    logic signed [24:0] sx, sy, sz;
    logic               ok;
    logic signed [31:0] curv;
    logic               cok;
    logic               last;
  } surf_word_t;

  class surf_scoreboard;
    surf_word_t pending[$];
    int         errors;
    cfg_t       cfg;

    function new();
      errors = 0;
      cfg.min_range = MinRangeRst;
      cfg.max_range = MaxRangeRst;
      cfg.sensor_offset = OffsetRst;
      cfg.sensor_separation = SepRst;
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clip25(longint v);
      if (v > 16777215) return 16777215;
      if (v < -16777216) return -16777216;
      return v;
    endfunction

    task report(string field, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", field, got, want);
    endtask

    function void note_finger(in_t f);
      longint w, x, y, z, dd, curv;
      longint tip[3], beam[3], xcol[3], pos[2][3], off;
      longint unsigned d[2], mag, den, num, q;
      logic ok[2];
      surf_word_t r;
      w = f.quat_w; x = f.quat_x; y = f.quat_y; z = f.quat_z;
      tip[0] = f.tip_x; tip[1] = f.tip_y; tip[2] = f.tip_z;
      d[0] = f.dist_a; d[1] = f.dist_b;
      ok[0] = f.flag_a && d[0] >= cfg.min_range && d[0] <= cfg.max_range;
      ok[1] = f.flag_b && d[1] >= cfg.min_range && d[1] <= cfg.max_range;
      beam[0] = round_shift(x * z + y * w, 13);
      beam[1] = round_shift(y * z - x * w, 13);
      beam[2] = 16384 - round_shift(x * x + y * y, 13);
      xcol[0] = 16384 - round_shift(y * y + z * z, 13);
      xcol[1] = round_shift(x * y + z * w, 13);
      xcol[2] = round_shift(x * z - y * w, 13);
      for (int i = 0; i < 3; i++) begin
        off = round_shift(longint'(cfg.sensor_offset) * xcol[i], 14);
        pos[0][i] = tip[i] + off;
        pos[1][i] = tip[i] - off;
      end
      for (int s = 0; s < 2; s++) begin
        r.kind = (s == 0) ? KindA : KindB;
        r.vx = clip25(pos[s][0]);
        r.vy = clip25(pos[s][1]);
        r.vz = clip25(pos[s][2]);
        r.sx = ok[s] ? clip25(pos[s][0] + round_shift(longint'(d[s]) * beam[0], 14)) : 0;
        r.sy = ok[s] ? clip25(pos[s][1] + round_shift(longint'(d[s]) * beam[1], 14)) : 0;
        r.sz = ok[s] ? clip25(pos[s][2] + round_shift(longint'(d[s]) * beam[2], 14)) : 0;
        r.ok = ok[s];
        r.curv = 0;
        r.cok = 0;
        r.last = 0;
        pending.push_back(r);
      end
      curv = 0;
      r.cok = ok[0] && ok[1];
      if (r.cok) begin
        dd = longint'(d[0]) - longint'(d[1]);
        mag = (dd < 0) ? -dd : dd;
        den = longint'(cfg.sensor_separation) * cfg.sensor_separation + mag * mag;
        if (den != 0) begin
          num = 2 * mag * 1000000 * 65536;
          q = (2 * num + den) / (2 * den);
          if (dd >= 0) curv = (q > 64'd2147483647) ? 2147483647 : q;
          else curv = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        end
      end
      r.kind = KindSum;
      r.vx = clip25(beam[0]);
      r.vy = clip25(beam[1]);
      r.vz = clip25(beam[2]);
      r.sx = 0; r.sy = 0; r.sz = 0;
      r.ok = 0;
      r.curv = curv;
      r.last = 1;
      pending.push_back(r);
    endfunction

    task check_word(surf_word_t g);
      surf_word_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("unexpected result word, kind %0d", g.kind);
        return;
      end
      e = pending.pop_front();
      if (g.kind !== e.kind) report("kind", g.kind, e.kind);
      if (g.vx !== e.vx) report("vec_x", g.vx, e.vx);
      if (g.vy !== e.vy) report("vec_y", g.vy, e.vy);
      if (g.vz !== e.vz) report("vec_z", g.vz, e.vz);
      if (g.sx !== e.sx) report("surf_x", g.sx, e.sx);
      if (g.sy !== e.sy) report("surf_y", g.sy, e.sy);
      if (g.sz !== e.sz) report("surf_z", g.sz, e.sz);
      if (g.ok !== e.ok) report("reading_ok", g.ok, e.ok);
      if (g.curv !== e.curv) report("curvature", g.curv, e.curv);
      if (g.cok !== e.cok) report("curvature_ok", g.cok, e.cok);
      if (g.last !== e.last) report("last", g.last, e.last);
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        calm = 0;
  int          stall_left = 0;

  tfsp_in_if  fin_if ();
  tfsp_out_if fout_if ();

  tof_finger_surface_points uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(fin_if.sink), .out_o(fout_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  surf_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  initial begin
    fin_if.valid = 0;
    {fin_if.quat_w, fin_if.quat_x, fin_if.quat_y, fin_if.quat_z} = '0;
    {fin_if.tip_x, fin_if.tip_y, fin_if.tip_z} = '0;
    {fin_if.dist_a, fin_if.dist_b, fin_if.flag_a, fin_if.flag_b} = '0;
    fout_if.ready = 0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      fout_if.ready <= 0;
    end else begin
      stall_left <= pick_gap();
      fout_if.ready <= 1;
    end
  end

  always @(posedge clk_i) begin
    surf_word_t g;
    if (rst_ni && fout_if.valid && fout_if.ready) begin
      g.kind = fout_if.kind;
      g.vx = fout_if.vec_x; g.vy = fout_if.vec_y; g.vz = fout_if.vec_z;
      g.sx = fout_if.surf_x; g.sy = fout_if.surf_y; g.sz = fout_if.surf_z;
      g.ok = fout_if.reading_ok;
      g.curv = fout_if.curvature;
      g.cok = fout_if.curvature_ok;
      g.last = fout_if.last;
      sb.check_word(g);
    end
  end

  task reg_write(logic [3:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data; penable <= 0;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    case (addr)
      AddrMinRange: sb.cfg.min_range = data[21:0];
      AddrMaxRange: sb.cfg.max_range = data[21:0];
      AddrOffset:   sb.cfg.sensor_offset = data[15:0];
      AddrSep:      sb.cfg.sensor_separation = data[16:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task set_config(int mn, int mx, int off, int sep);
    reg_write(AddrMinRange, mn);
    reg_write(AddrMaxRange, mx);
    reg_write(AddrOffset, off);
    reg_write(AddrSep, sep);
  endtask

  task send_finger(in_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      fin_if.valid <= 0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    fin_if.valid <= 1;
    fin_if.quat_w <= f.quat_w; fin_if.quat_x <= f.quat_x;
    fin_if.quat_y <= f.quat_y; fin_if.quat_z <= f.quat_z;
    fin_if.tip_x <= f.tip_x; fin_if.tip_y <= f.tip_y; fin_if.tip_z <= f.tip_z;
    fin_if.dist_a <= f.dist_a; fin_if.dist_b <= f.dist_b;
    fin_if.flag_a <= f.flag_a; fin_if.flag_b <= f.flag_b;
    do @(posedge clk_i); while (!fin_if.ready);
    sb.note_finger(f);
  endtask

  task drain();
    @(negedge clk_i);
    fin_if.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  function in_t make_finger(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                            logic [15:0] z, int tp, int da, int db, logic fa, logic fb);
    in_t f;
    f.quat_w = w; f.quat_x = x; f.quat_y = y; f.quat_z = z;
    f.tip_x = 24'(tp); f.tip_y = 24'(-tp); f.tip_z = 24'(tp / 2);
    f.dist_a = 22'(da); f.dist_b = 22'(db); f.flag_a = fa; f.flag_b = fb;
    return f;
  endfunction

  function in_t random_finger();
    in_t f;
    real ang, ax, ay, az, n, s;
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      ang = $urandom_range(0, 62831) / 10000.0;
      ax = $urandom_range(0, 2000) - 1000.0;
      ay = $urandom_range(0, 2000) - 1000.0;
      az = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(ax * ax + ay * ay + az * az) + 1.0e-9;
      s = $sin(ang / 2.0) * 16384.0 / n;
      f.quat_w = 16'($rtoi($cos(ang / 2.0) * 16384.0));
      f.quat_x = 16'($rtoi(ax * s));
      f.quat_y = 16'($rtoi(ay * s));
      f.quat_z = 16'($rtoi(az * s));
    end else begin
      f.quat_w = 16'($urandom); f.quat_x = 16'($urandom);
      f.quat_y = 16'($urandom); f.quat_z = 16'($urandom);
    end
    if ($urandom_range(0, 9) < 8) begin
      f.tip_x = 24'($urandom_range(0, 400000) - 200000);
      f.tip_y = 24'($urandom_range(0, 400000) - 200000);
      f.tip_z = 24'($urandom_range(0, 400000) - 200000);
    end else begin
      f.tip_x = 24'($urandom); f.tip_y = 24'($urandom); f.tip_z = 24'($urandom);
    end
    r = $urandom_range(0, 9);
    if (r < 7) begin
      f.dist_a = 22'($urandom_range(sb.cfg.min_range, sb.cfg.max_range));
      f.dist_b = (r < 4) ? 22'(f.dist_a + $urandom_range(0, 8000) - 4000)
                         : 22'($urandom_range(sb.cfg.min_range, sb.cfg.max_range));
    end else begin
      f.dist_a = 22'($urandom); f.dist_b = 22'($urandom);
    end
    f.flag_a = $urandom_range(0, 9) != 0;
    f.flag_b = $urandom_range(0, 9) != 0;
    return f;
  endfunction

  task run_phase(int count);
    send_finger(make_finger(16'sd16384, 0, 0, 0, 0, sb.cfg.min_range,
                            sb.cfg.max_range, 1, 1));
    send_finger(make_finger(0, 16'sd16384, 0, 0, 1000, sb.cfg.min_range - 1,
                            sb.cfg.max_range + 1, 1, 1));
    send_finger(make_finger(0, 0, 16'sd16384, 0, -1000, 100000, 90000, 1, 1));
    send_finger(make_finger(0, 0, 0, 16'sd16384, 5, 90000, 100000, 1, 1));
    send_finger(make_finger(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
                            0, 50000, 50000, 1, 1));
    send_finger(make_finger(16'h8000, 16'h8000, 16'h8000, 16'h8000, 8388607,
                            4194303, 4194303, 1, 1));
    send_finger(make_finger(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, -8388608,
                            0, 4194303, 1, 1));
    send_finger(make_finger(11585, 11585, 0, 0, 8388607, 2000000, 20000, 0, 1));
    send_finger(make_finger(11585, 0, 0, 11585, -8388608, 20000, 2000000, 1, 0));
    send_finger(make_finger(0, 0, 0, 0, 0, 30000, 30001, 0, 0));
    send_finger(make_finger(8192, 8192, 8192, 8192, 123456, 20001, 1999999, 1, 1));
    send_finger(make_finger(16384, 0, 0, 0, 0, 4194303, 0, 1, 1));
    for (int i = 0; i < count; i++) send_finger(random_finger());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    repeat (3) @(posedge clk_i);
    calm = 1;
    run_phase(40);
    calm = 0;
    run_phase(80);
    set_config(0, 4194303, 65535, 1);
    run_phase(80);
    set_config(500000, 400000, 0, 131071);
    run_phase(30);
    set_config(1000, 3000000, 30000, 0);
    run_phase(50);
    set_config($urandom_range(0, 100000), $urandom_range(1000000, 4194303),
               $urandom, $urandom_range(1, 131071));
    run_phase(80);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0d expected words never arrived", sb.pending.size());
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
